// ===== rtl/core/poly_pkg.sv =====
// shared types and constants for the polynomial evaluator
package poly_pkg;

    localparam int MAX_DEGREE = 6;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int DEGREE_W   = 3;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W      = ((SHIFT_W > DATA_W) ? SHIFT_W : DATA_W) + 1;
    localparam int NUM_STEPS  = MAX_DEGREE;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE = 3'd0,
        REG_COEF_0 = 3'd1,
        REG_COEF_1 = 3'd2,
        REG_COEF_2 = 3'd3,
        REG_COEF_3 = 3'd4,
        REG_COEF_4 = 3'd5,
        REG_COEF_5 = 3'd6,
        REG_COEF_6 = 3'd7
    } cfg_index_t;

    // item payload as it moves between horner steps
    typedef struct packed {
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x;
        logic [DEGREE_W-1:0]      deg;
        logic                     sat;
    } horner_t;

    // occupancy of the two register stages inside one step
    typedef struct packed {
        logic mul_valid;
        logic add_valid;
    } step_status_t;

endpackage

// ===== rtl/core/poly_horner_step.sv =====
// one horner step: multiply stage, then shift, add and saturate stage
module poly_horner_step (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [poly_pkg::DEGREE_W-1:0]     coef_idx,
    input  logic signed [poly_pkg::DATA_W-1:0] coef,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  poly_pkg::horner_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output poly_pkg::horner_t                 out_item,
    output poly_pkg::step_status_t            status
);
    import poly_pkg::*;

    logic                      mul_valid_reg;
    logic                      mul_valid_next;
    logic signed [PROD_W-1:0]  prod_reg;
    horner_t                   mul_item_reg;
    logic                      add_valid_reg;
    logic                      add_valid_next;
    horner_t                   add_item_reg;
    horner_t                   add_item_next;
    logic                      mul_ready;
    logic                      add_ready;
    logic                      active;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [SUM_W-1:0]   sum;
    logic                      ovf;

    assign add_ready = !add_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || add_ready;
    assign in_ready  = mul_ready;

    assign mul_valid_next = mul_ready ? in_valid : mul_valid_reg;
    assign add_valid_next = add_ready ? mul_valid_reg : add_valid_reg;

    // steps whose coefficient index is at or above the item's degree pass the accumulator through
    assign active  = mul_item_reg.deg > coef_idx;
    assign shifted = SHIFT_W'(prod_reg >>> FRAC_BITS);
    assign sum     = SUM_W'(shifted) + SUM_W'(coef);
    assign ovf     = !(&sum[SUM_W-1:DATA_W-1]) && (|sum[SUM_W-1:DATA_W-1]);

    always_comb begin
        add_item_next = mul_item_reg;
        if (active) begin
            if (ovf) begin
                add_item_next.acc = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : {1'b0, {(DATA_W-1){1'b1}}};
                add_item_next.sat = 1'b1;
            end else begin
                add_item_next.acc = sum[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            add_valid_reg <= add_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            prod_reg     <= PROD_W'(in_item.acc) * PROD_W'(in_item.x);
            mul_item_reg <= in_item;
        end
        if (add_ready && mul_valid_reg) begin
            add_item_reg <= add_item_next;
        end
    end

    assign out_valid        = add_valid_reg;
    assign out_item         = add_item_reg;
    assign status.mul_valid = mul_valid_reg;
    assign status.add_valid = add_valid_reg;

endmodule

// ===== rtl/core/polynomial_evaluator_top.sv =====
// polynomial evaluator top level: config registers, entry stage and horner pipeline
//
// evaluates p(x) = c0 + c1*x + ... + c6*x^6 in signed Q16.16 by horner's rule.
// s_axis carries one point x per item; m_axis returns p(x) with a flag in tuser
// that is set when any horner step clipped to the signed 32-bit range.
// the degree and coefficients are written through the cfg_wr_* port, one
// register per cycle; the user must write them only while no item is in flight,
// which the block does not enforce; a degree above six acts as six and higher
// coefficients are ignored. the pipeline is an entry stage that picks the leading
// coefficient and six horner steps of two stages each (a 32x32 multiply, then
// shift, add and saturate).
// throughput is one item per cycle while the receiver takes items; every stage
// has its own valid bit and ready is chained back stage by stage, so a stalled
// receiver only holds the items that are stacked up behind the output register
// and bubbles close up. reset (aresetn low, synchronous) clears the config
// registers to zero and drops all items in flight.
module polynomial_evaluator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [poly_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [poly_pkg::DATA_W-1:0]        cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [poly_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] x_point
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [poly_pkg::DATA_W-1:0]        m_axis_tdata,  // [31:0] poly_value
    output logic                               m_axis_tuser   // [0] saturated
);
    import poly_pkg::*;

    logic [DEGREE_W-1:0]      degree_reg;
    logic signed [DATA_W-1:0] coef_reg [0:MAX_DEGREE];
    logic [DEGREE_W-1:0]      deg_eff;
    logic                     entry_valid_reg;
    logic                     entry_valid_next;
    horner_t                  entry_reg;
    horner_t                  entry_next;
    logic                     entry_ready;

    logic                     step_valid [0:NUM_STEPS];
    logic                     step_ready [0:NUM_STEPS];
    horner_t                  step_item  [0:NUM_STEPS];
    step_status_t             step_status [0:NUM_STEPS-1];
    logic [2*NUM_STEPS:0]     occ_bits;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
            for (int i = 0; i <= MAX_DEGREE; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_DEGREE: degree_reg  <= cfg_wr_data[DEGREE_W-1:0];
                REG_COEF_0: coef_reg[0] <= cfg_wr_data;
                REG_COEF_1: coef_reg[1] <= cfg_wr_data;
                REG_COEF_2: coef_reg[2] <= cfg_wr_data;
                REG_COEF_3: coef_reg[3] <= cfg_wr_data;
                REG_COEF_4: coef_reg[4] <= cfg_wr_data;
                REG_COEF_5: coef_reg[5] <= cfg_wr_data;
                REG_COEF_6: coef_reg[6] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign deg_eff = (degree_reg > DEGREE_W'(MAX_DEGREE)) ? DEGREE_W'(MAX_DEGREE)
                                                          : degree_reg;

    // entry stage: accumulator starts at the leading coefficient
    always_comb begin
        entry_next.acc = coef_reg[deg_eff];
        entry_next.x   = s_axis_tdata;
        entry_next.deg = deg_eff;
        entry_next.sat = 1'b0;
    end

    assign entry_ready      = !entry_valid_reg || step_ready[0];
    assign s_axis_tready    = entry_ready;
    assign entry_valid_next = entry_ready ? s_axis_tvalid : entry_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (entry_ready && s_axis_tvalid) begin
            entry_reg <= entry_next;
        end
    end

    assign step_valid[0] = entry_valid_reg;
    assign step_item[0]  = entry_reg;

    // step k folds in coefficient MAX_DEGREE-1-k
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        poly_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef_idx  (DEGREE_W'(MAX_DEGREE - 1 - k)),
            .coef      (coef_reg[MAX_DEGREE - 1 - k]),
            .in_valid  (step_valid[k]),
            .in_ready  (step_ready[k]),
            .in_item   (step_item[k]),
            .out_valid (step_valid[k+1]),
            .out_ready (step_ready[k+1]),
            .out_item  (step_item[k+1]),
            .status    (step_status[k])
        );
        assign occ_bits[2*k+1] = step_status[k].mul_valid;
        assign occ_bits[2*k+2] = step_status[k].add_valid;
    end

    assign occ_bits[0] = entry_valid_reg;

    assign step_ready[NUM_STEPS] = m_axis_tready;
    assign m_axis_tvalid         = step_valid[NUM_STEPS];
    assign m_axis_tdata          = step_item[NUM_STEPS].acc;
    assign m_axis_tuser          = step_item[NUM_STEPS].sat;

    // a stall at the input can only come from a stalled output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // the entry stage holds its item while the first step is full
    a_entry_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_valid_reg && !step_ready[0]) |=> (entry_valid_reg && $stable(entry_reg)))
        else $error("entry stage item lost during stall");

    // items in flight change only by accepts and deliveries
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(occ_bits) == $countones($past(occ_bits))
            + int'($past(s_axis_tvalid && s_axis_tready))
            - int'($past(m_axis_tvalid && m_axis_tready))))
        else $error("pipeline occupancy mismatch");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
